// File: rtl/core/qth_pkg.sv
// ----------------------------------------------------------------------------
// qth_pkg
// Types and constants shared by the quaternion-to-heading pipeline.
// ----------------------------------------------------------------------------
package qth_pkg;

  localparam int QUAT_W      = 16;
  localparam int PROD_W      = 32;   // Q1.14 x Q1.14 product
  localparam int SUM_W       = 35;   // unsaturated r11 / r21, Q6.28
  localparam int R_W         = 30;   // saturated to [-1, +1] in Q1.28
  localparam int VEC_W       = 32;   // CORDIC x / y with gain headroom
  localparam int ANG_W       = 27;   // CORDIC angle, 2^16 per degree
  localparam int SUM_ANG_W   = 28;   // angle plus offset
  localparam int OFFSET_W    = 9;
  localparam int HEADING_W   = 15;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;

  localparam logic signed [SUM_W-1:0]     Q28_ONE   = SUM_W'(64'sd268435456);
  localparam logic signed [ANG_W-1:0]     HALF_TURN = ANG_W'(64'sd11796480);
  localparam logic signed [SUM_ANG_W-1:0] FULL_TURN = SUM_ANG_W'(64'sd23592960);
  localparam logic [HEADING_W-1:0]        HEADING_MAX = 15'd23040;

  // atan(2^-n) in degrees, 2^16 units per degree
  localparam logic signed [ANG_W-1:0] ATAN_DEG_Q16 [ATAN_LEN] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
    27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
    27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
    27'sd917,     27'sd458,     27'sd229,    27'sd115,
    27'sd57,      27'sd29,      27'sd14,     27'sd7,
    27'sd4,       27'sd2,       27'sd1,      27'sd0
  };

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] z;
    logic                    zero;   // zero vector: yaw forced to 0
  } vec_t;

endpackage

// File: rtl/core/qth_cordic.sv
// ----------------------------------------------------------------------------
// qth_cordic
// Vectoring CORDIC, one micro-rotation per register stage, with a ready
// chain so empty stages fill while the output is held.
// ----------------------------------------------------------------------------
module qth_cordic #(
  parameter int STAGES = qth_pkg::CORDIC_STAGES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  output logic          s_ready,
  input  qth_pkg::vec_t s_vec,
  output logic          m_valid,
  input  logic          m_ready,
  output qth_pkg::vec_t m_vec
);

  qth_pkg::vec_t stv [0:STAGES];
  logic          vld [0:STAGES];
  logic          adv [1:STAGES+1];

  assign stv[0]          = s_vec;
  assign vld[0]          = s_valid;
  assign adv[STAGES+1]   = m_ready;
  assign s_ready         = adv[1];
  assign m_valid         = vld[STAGES];
  assign m_vec           = stv[STAGES];

  for (genvar k = 1; k <= STAGES; k++) begin : g_stage
    localparam int SH = k - 1;
    qth_pkg::vec_t nxt;

    assign adv[k] = !vld[k] || adv[k+1];

    always_comb begin
      nxt = stv[k-1];
      if (!stv[k-1].y[qth_pkg::VEC_W-1]) begin
        nxt.x = stv[k-1].x + ($signed(stv[k-1].y) >>> SH);
        nxt.y = stv[k-1].y - ($signed(stv[k-1].x) >>> SH);
        nxt.z = stv[k-1].z + qth_pkg::ATAN_DEG_Q16[SH];
      end else begin
        nxt.x = stv[k-1].x - ($signed(stv[k-1].y) >>> SH);
        nxt.y = stv[k-1].y + ($signed(stv[k-1].x) >>> SH);
        nxt.z = stv[k-1].z - qth_pkg::ATAN_DEG_Q16[SH];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k] && vld[k-1]) begin
        stv[k] <= nxt;
      end
    end
  end

endmodule

// File: rtl/core/quaternion_to_heading.sv
// ----------------------------------------------------------------------------
// quaternion_to_heading
// Yaw heading from a unit quaternion, offset and wrapped to 0..360 degrees.
// ----------------------------------------------------------------------------
// Each beat on s_ carries one Q1.14 quaternion; each beat on m_ returns its
// heading in 1/64 degree (0..23040). The block is a pipeline that takes one
// beat per clock unless m_tready stalls it: three front stages (products,
// r11/r21 with saturation, half-turn pre-rotation), CORDIC_STAGES CORDIC
// stages of one micro-rotation each, and three back stages (offset add, wrap,
// clamp and rounding). Each stage has its own valid bit and a stage may fill
// while a later one is held, so a stalled output does not stop input while
// empty stages remain. The heading offset is written on the cfg_ port, always
// ready, and should only change while the pipeline is empty.
module quaternion_to_heading #(
  parameter int CORDIC_STAGES = qth_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,    // quat_real[15:0], quat_i[31:16],
                                  // quat_j[47:32], quat_k[63:48]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // heading[14:0], zero pad [15]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data    // heading_offset_deg, signed
);

  localparam int SW  = qth_pkg::SUM_W;
  localparam int RW  = qth_pkg::R_W;
  localparam int VW  = qth_pkg::VEC_W;
  localparam int AW  = qth_pkg::ANG_W;
  localparam int SAW = qth_pkg::SUM_ANG_W;

  // configuration
  logic signed [qth_pkg::OFFSET_W-1:0] heading_offset_deg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_offset_deg <= '0;
    end else if (cfg_valid) begin
      heading_offset_deg <= cfg_data;
    end
  end

  // ready chain
  logic p_v, r_v, pr_v, a_v, w_v, o_v;
  logic p_adv, r_adv, pr_adv, a_adv, w_adv, o_adv;
  logic c_s_ready, c_m_valid;
  qth_pkg::vec_t pr_vec, c_m_vec;

  assign o_adv    = !o_v || m_tready;
  assign w_adv    = !w_v || o_adv;
  assign a_adv    = !a_v || w_adv;
  assign pr_adv   = !pr_v || c_s_ready;
  assign r_adv    = !r_v || pr_adv;
  assign p_adv    = !p_v || r_adv;
  assign s_tready = p_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v  <= 1'b0;
      r_v  <= 1'b0;
      pr_v <= 1'b0;
      a_v  <= 1'b0;
      w_v  <= 1'b0;
      o_v  <= 1'b0;
    end else begin
      if (p_adv)  p_v  <= s_tvalid;
      if (r_adv)  r_v  <= p_v;
      if (pr_adv) pr_v <= r_v;
      if (a_adv)  a_v  <= c_m_valid;
      if (w_adv)  w_v  <= a_v;
      if (o_adv)  o_v  <= w_v;
    end
  end

  // stage 1: products
  logic signed [qth_pkg::QUAT_W-1:0] quat_real, quat_i, quat_j, quat_k;
  logic signed [qth_pkg::PROD_W-1:0] p_jj, p_kk, p_ij, p_rk;

  assign quat_real = s_tdata[15:0];
  assign quat_i    = s_tdata[31:16];
  assign quat_j    = s_tdata[47:32];
  assign quat_k    = s_tdata[63:48];

  always_ff @(posedge clk) begin
    if (p_adv && s_tvalid) begin
      p_jj <= quat_j * quat_j;
      p_kk <= quat_k * quat_k;
      p_ij <= quat_i * quat_j;
      p_rk <= quat_real * quat_k;
    end
  end

  // stage 2: matrix elements, saturated to [-1, +1]
  logic signed [SW-1:0] r11_full, r21_full;
  logic signed [RW-1:0] r11_sat, r21_sat, r11, r21;

  always_comb begin
    r11_full = qth_pkg::Q28_ONE - ((SW'(p_jj) + SW'(p_kk)) <<< 1);
    r21_full = (SW'(p_ij) + SW'(p_rk)) <<< 1;
    if (r11_full > qth_pkg::Q28_ONE)       r11_sat = RW'(qth_pkg::Q28_ONE);
    else if (r11_full < -qth_pkg::Q28_ONE) r11_sat = RW'(-qth_pkg::Q28_ONE);
    else                                   r11_sat = RW'(r11_full);
    if (r21_full > qth_pkg::Q28_ONE)       r21_sat = RW'(qth_pkg::Q28_ONE);
    else if (r21_full < -qth_pkg::Q28_ONE) r21_sat = RW'(-qth_pkg::Q28_ONE);
    else                                   r21_sat = RW'(r21_full);
  end

  always_ff @(posedge clk) begin
    if (r_adv && p_v) begin
      r11 <= r11_sat;
      r21 <= r21_sat;
    end
  end

  // stage 3: bring x into the right half-plane
  qth_pkg::vec_t pr_next;
  logic signed [VW-1:0] x_ext, y_ext;

  always_comb begin
    x_ext        = VW'(r11);
    y_ext        = VW'(r21);
    pr_next.zero = (r11 == '0) && (r21 == '0);
    if (r11[RW-1]) begin
      pr_next.x = -x_ext;
      pr_next.y = -y_ext;
      pr_next.z = r21[RW-1] ? -qth_pkg::HALF_TURN : qth_pkg::HALF_TURN;
    end else begin
      pr_next.x = x_ext;
      pr_next.y = y_ext;
      pr_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (pr_adv && r_v) begin
      pr_vec <= pr_next;
    end
  end

  qth_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .s_valid (pr_v),
    .s_ready (c_s_ready),
    .s_vec   (pr_vec),
    .m_valid (c_m_valid),
    .m_ready (a_adv),
    .m_vec   (c_m_vec)
  );

  // back stage A: add offset
  logic signed [SAW-1:0] ang_sum, ang_sum_next;

  always_comb begin
    ang_sum_next = {{(SAW-qth_pkg::OFFSET_W-16){heading_offset_deg[qth_pkg::OFFSET_W-1]}},
                    heading_offset_deg, 16'd0};
    if (!c_m_vec.zero) begin
      ang_sum_next = ang_sum_next + SAW'(c_m_vec.z);
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && c_m_valid) begin
      ang_sum <= ang_sum_next;
    end
  end

  // back stage B: single wrap
  logic signed [SAW-1:0] ang_wrap, ang_wrap_next;

  always_comb begin
    if (ang_sum > qth_pkg::FULL_TURN)  ang_wrap_next = ang_sum - qth_pkg::FULL_TURN;
    else if (ang_sum[SAW-1])           ang_wrap_next = ang_sum + qth_pkg::FULL_TURN;
    else                               ang_wrap_next = ang_sum;
  end

  always_ff @(posedge clk) begin
    if (w_adv && a_v) begin
      ang_wrap <= ang_wrap_next;
    end
  end

  // back stage C: clamp, round to 1/64 degree
  logic signed [SAW-1:0] ang_clamp, ang_round;
  logic [qth_pkg::HEADING_W-1:0] heading;

  always_comb begin
    if (ang_wrap[SAW-1])                       ang_clamp = '0;
    else if (ang_wrap > qth_pkg::FULL_TURN)    ang_clamp = qth_pkg::FULL_TURN;
    else                                       ang_clamp = ang_wrap;
    ang_round = ang_clamp + SAW'(512);
  end

  always_ff @(posedge clk) begin
    if (o_adv && w_v) begin
      heading <= ang_round[24:10];
    end
  end

  assign m_tvalid = o_v;
  assign m_tdata  = {1'b0, heading};

  // checks
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    o_v |-> heading <= qth_pkg::HEADING_MAX)
    else $error("heading beyond 360 degrees");

  a_prerot_right_half: assert property (@(posedge clk) disable iff (rst)
    pr_v |-> !pr_vec.x[VW-1])
    else $error("pre-rotation left x negative");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    (pr_v && pr_vec.zero) |-> (pr_vec.x == '0 && pr_vec.y == '0 && pr_vec.z == '0))
    else $error("zero vector flag set on non-zero vector");

  a_bubble_fill: assert property (@(posedge clk) disable iff (rst)
    !p_v |-> s_tready)
    else $error("input held while first stage empty");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (o_v && !m_tready && w_v) |=> (o_v && w_v))
    else $error("pipeline lost a beat under output stall");

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quaternion-to-heading pipeline.
// ----------------------------------------------------------------------------
// Quaternion beats come from a queue that the main sequence fills, phase by
// phase, with a heading offset written before each phase but the first. Every accepted input
// beat is run through a local copy of the yaw, CORDIC, offset and wrap
// arithmetic. The heading it gives is queued, and each output beat is checked
// against the oldest queued heading. Both sides idle at random, and once the
// output side holds off long enough to fill the pipeline.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     STAGES         = qth_pkg::CORDIC_STAGES_DEF;
  localparam int     LATENCY        = STAGES + 6;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     LONG_HOLD      = 150;
  localparam int     PHASES         = 8;
  localparam int     PHASE_ITEMS    = 142;
  localparam longint Q28            = 64'sd268435456;
  localparam longint DEG            = 64'sd65536;
  localparam longint FULL_DEG       = 360 * DEG;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [8:0]  cfg_data;

  logic [63:0]       quat_pending [$];
  logic [63:0]       corner_quats [$];
  logic [15:0]       headings_due [$];
  logic [15:0]       want;
  logic signed [8:0] offset_now;

  int errors;
  int cfg_beats;
  int idle_cycles;
  bit s_beat_done;
  int gap_left;
  int gapless_left;
  int steady_left;
  bit hold_request;
  int hold_left;
  int ready_run;
  int rx_pick;

  quaternion_to_heading i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] quat_beat(int r, int i, int j, int k);
    return {16'(k), 16'(j), 16'(i), 16'(r)};
  endfunction

  // yaw = atan2(r21, r11) by vectoring CORDIC, plus offset, wrapped once, clamped and rounded
  function automatic logic [14:0] yaw_heading(logic [63:0] beat, logic signed [8:0] offs);
    longint qr, qi, qj, qk, r11, r21, x, y, z, xs, ys, ang;
    qr  = longint'($signed(beat[15:0]));
    qi  = longint'($signed(beat[31:16]));
    qj  = longint'($signed(beat[47:32]));
    qk  = longint'($signed(beat[63:48]));
    r11 = Q28 - 2 * (qj * qj + qk * qk);
    r21 = 2 * (qi * qj + qr * qk);
    if (r11 > Q28) r11 = Q28;
    if (r11 < -Q28) r11 = -Q28;
    if (r21 > Q28) r21 = Q28;
    if (r21 < -Q28) r21 = -Q28;
    x = r11;
    y = r21;
    z = 0;
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        z = (y >= 0) ? 180 * DEG : -180 * DEG;
        x = -x;
        y = -y;
      end
      for (int n = 0; n < STAGES && n < qth_pkg::ATAN_LEN; n++) begin
        xs = x >>> n;
        ys = y >>> n;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(qth_pkg::ATAN_DEG_Q16[n]);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(qth_pkg::ATAN_DEG_Q16[n]);
        end
      end
    end
    ang = z + longint'(offs) * DEG;
    if (ang > FULL_DEG) ang = ang - FULL_DEG;
    if (ang < 0) ang = ang + FULL_DEG;
    if (ang < 0) ang = 0;
    if (ang > FULL_DEG) ang = FULL_DEG;
    return 15'((ang + 512) >>> 10);
  endfunction

  function automatic logic [63:0] unit_quat();
    real c [4];
    real norm;
    int  q [4];
    norm = 0.0;
    for (int n = 0; n < 4; n++) begin
      c[n] = real'($urandom_range(0, 32768)) - 16384.0;
      norm = norm + c[n] * c[n];
    end
    if (norm < 1.0) return quat_beat(16384, 0, 0, 0);
    norm = $sqrt(norm);
    for (int n = 0; n < 4; n++) q[n] = int'(c[n] * 16384.0 / norm);
    return quat_beat(q[0], q[1], q[2], q[3]);
  endfunction

  // mostly unit quaternions, then loose ones, raw bit patterns and corners
  function automatic logic [63:0] random_quat();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return unit_quat();
    if (pick < 80)
      return quat_beat(int'($urandom_range(0, 32768)) - 16384,
                       int'($urandom_range(0, 32768)) - 16384,
                       int'($urandom_range(0, 32768)) - 16384,
                       int'($urandom_range(0, 32768)) - 16384);
    if (pick < 90) return {$urandom, $urandom};
    return corner_quats[$urandom_range(0, corner_quats.size() - 1)];
  endfunction

  function automatic int next_gap();
    int pick;
    if (steady_left > 0 || gapless_left > 0) begin
      if (gapless_left > 0) gapless_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      gapless_left = $urandom_range(10, 60);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // quaternion driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      gap_left = 0;
    end else begin
      if (!s_tvalid || s_beat_done) begin
        s_beat_done = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (quat_pending.size() > 0) begin
          s_tdata  <= quat_pending.pop_front();
          s_tvalid <= 1'b1;
          gap_left = next_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      if (steady_left > 0) steady_left--;
    end
  end

  // heading receiver
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
      ready_run = 0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (ready_run > 0) begin
      ready_run--;
      m_tready <= 1'b1;
    end else begin
      rx_pick = $urandom_range(0, 99);
      if (rx_pick < 70) begin
        ready_run = $urandom_range(0, 12);
        m_tready <= 1'b1;
      end else if (rx_pick < 96) begin
        hold_left = $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        hold_left = $urandom_range(8, 40);
        m_tready <= 1'b0;
      end
    end
  end

  // monitor: predict on input beats, check on output beats
  always @(posedge clk) begin
    if (rst) begin
      offset_now = '0;
      idle_cycles = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        headings_due.push_back({1'b0, yaw_heading(s_tdata, offset_now)});
        s_beat_done = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (headings_due.size() == 0) begin
          $display("%0t: heading beat 0x%04h with none expected", $time, m_tdata);
          errors++;
        end else begin
          want = headings_due.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: heading expected 0x%04h, got 0x%04h", $time, want, m_tdata);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        offset_now = cfg_data;
        cfg_beats++;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else if (quat_pending.size() > 0 || s_tvalid || headings_due.size() > 0 || cfg_valid)
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_offset(logic signed [8:0] deg);
    int target;
    target = cfg_beats + 1;
    @(negedge clk);
    cfg_data  <= deg;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (cfg_beats != target) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (quat_pending.size() != 0 || s_tvalid || headings_due.size() != 0);
  endtask

  initial begin
    int phase_offsets [PHASES];
    logic signed [8:0] deg;
    phase_offsets = '{0, 180, -180, 255, -256, -1, 90, 0};
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    errors    = 0;
    cfg_beats = 0;

    corner_quats.push_back(quat_beat(16384, 0, 0, 0));       // identity
    corner_quats.push_back(quat_beat(-16384, 0, 0, 0));
    corner_quats.push_back(quat_beat(0, 0, 0, 16384));       // r11 < 0, r21 = 0
    corner_quats.push_back(quat_beat(0, 0, 0, -16384));
    corner_quats.push_back(quat_beat(0, 16384, 0, 0));
    corner_quats.push_back(quat_beat(0, 0, 16384, 0));
    corner_quats.push_back(quat_beat(11585, 0, 0, 11585));   // +90
    corner_quats.push_back(quat_beat(11585, 0, 0, -11585));  // -90, wraps
    corner_quats.push_back(quat_beat(0, 0, 8192, 8192));     // zero vector
    corner_quats.push_back(quat_beat(100, 0, 8192, 8192));   // r11 = 0, r21 > 0
    corner_quats.push_back(quat_beat(-100, 0, 8192, 8192));  // r11 = 0, r21 < 0
    corner_quats.push_back(quat_beat(1000, 0, 0, 16000));    // r11 < 0, r21 > 0
    corner_quats.push_back(quat_beat(-1000, 0, 0, 16000));   // r11 < 0, r21 < 0
    corner_quats.push_back(quat_beat(0, 0, 0, 0));
    corner_quats.push_back(quat_beat(32767, 32767, 32767, 32767));
    corner_quats.push_back(quat_beat(-32768, -32768, -32768, -32768));
    corner_quats.push_back(quat_beat(32767, -32768, 32767, -32768));
    corner_quats.push_back(quat_beat(16384, 16384, 16384, 16384));
    corner_quats.push_back(quat_beat(-16384, 16384, -16384, 16384));
    corner_quats.push_back(quat_beat(8192, 8192, 8192, 8192));
    corner_quats.push_back(quat_beat(-1, -1, -1, -1));
    corner_quats.push_back(quat_beat(1, 1, 1, 1));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      // phase 0 runs on the reset value of the offset
      if (ph > 0) begin
        deg = (ph == PHASES - 1) ? 9'(int'($urandom_range(0, 511)) - 256)
                                 : 9'(phase_offsets[ph]);
        write_offset(deg);
      end
      if (ph == 0)
        foreach (corner_quats[n]) quat_pending.push_back(corner_quats[n]);
      for (int n = 0; n < PHASE_ITEMS; n++) quat_pending.push_back(random_quat());
      // long output stall with the sender still pushing: pipeline fills up
      if (ph == 2) begin
        @(posedge clk);
        steady_left  = LONG_HOLD;
        hold_request = 1'b1;
      end
      wait_drained();
      repeat (LATENCY) @(negedge clk);
    end

    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
